// ----- rtl/lss_pkg.sv -----
// Shared types and constants for the 3x3 linear solver.
`timescale 1ns / 1ps
package lss_pkg;

    localparam int W         = 32;         // Q16.16 word
    localparam int FRAC      = 16;         // fraction bits
    localparam int THR_W     = 31;         // threshold register width
    localparam int CW        = 2 * W + 1;  // 2x2 cofactor
    localparam int PW        = 2 * W + 1;  // partial product of cofactor half and word
    localparam int SW        = 3 * W + 1;  // signed 3x3 determinant
    localparam int MW        = 3 * W;      // determinant magnitude
    localparam int NW        = MW + FRAC;  // scaled numerator
    localparam int QB        = W + 1;      // quotient bits developed by the divider
    localparam int QW        = QB + 1;     // quotient after rounding
    localparam int RW        = MW + QB;    // divider remainder
    localparam int FRONT_LAT = 7;          // register stages in the determinant front end
    localparam int DIV_LAT   = QB + 2;     // register stages in each divider

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
    localparam logic [QW-1:0]    POS_LIM   = QW'(64'h7FFF_FFFF);
    localparam logic [QW-1:0]    NEG_LIM   = QW'(64'h8000_0000);
    localparam logic [W-1:0]     X_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [W-1:0]     X_NEG_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [W-1:0] a00;
        logic signed [W-1:0] a01;
        logic signed [W-1:0] a02;
        logic signed [W-1:0] a10;
        logic signed [W-1:0] a11;
        logic signed [W-1:0] a12;
        logic signed [W-1:0] a20;
        logic signed [W-1:0] a21;
        logic signed [W-1:0] a22;
        logic signed [W-1:0] b0;
        logic signed [W-1:0] b1;
        logic signed [W-1:0] b2;
    } in_t;

    typedef struct packed {
        logic                solved;
        logic signed [W-1:0] x0;
        logic signed [W-1:0] x1;
        logic signed [W-1:0] x2;
        logic                saturated;
    } out_t;

    typedef struct packed {
        logic [NW-1:0] num;
        logic [MW-1:0] den;
        logic          neg;
    } div_in_t;

endpackage

// ----- rtl/lss_front.sv -----
// Determinant front end: pair products, cofactors, triple sums, magnitudes, threshold test.
`timescale 1ns / 1ps
module lss_front
(
    input  logic                            clk,
    input  logic                            ce,
    input  lss_pkg::in_t                    din,
    input  logic [lss_pkg::THR_W-1:0]       thr,
    output lss_pkg::div_in_t [2:0]          div_in,
    output logic                            solved
);
    import lss_pkg::*;

    logic signed [W-1:0]  m [3][3];
    logic signed [W-1:0]  b [3];
    logic signed [2*W-1:0] ppa_reg [3][3];
    logic signed [2*W-1:0] ppb_reg [3][3];
    logic signed [W-1:0]  m1_reg [3];
    logic signed [W-1:0]  b1_reg [3];
    logic signed [W-1:0]  m2_reg [3];
    logic signed [W-1:0]  b2_reg [3];
    logic signed [CW-1:0] cof_reg [3][3];
    logic signed [W-1:0]  coef_op [4][3];
    logic signed [CW-1:0] cof_op [4][3];
    logic signed [PW-1:0] hi_reg [4][3];
    logic signed [PW-1:0] lo_reg [4][3];
    logic signed [SW-1:0] term_reg [4][3];
    logic signed [SW-1:0] sum_reg [4];
    logic signed [SW-1:0] abs_v [4];
    logic [MW-1:0]        mag_reg [4];
    logic                 neg_reg [4];
    logic [MW:0]          rnd_sum;
    logic                 solved_reg;
    div_in_t [2:0]        div_reg;

    localparam logic [MW:0] RND_HALF = (MW+1)'(1) << (W - 1);

    always_comb
    begin
        m[0][0] = din.a00; m[0][1] = din.a01; m[0][2] = din.a02;
        m[1][0] = din.a10; m[1][1] = din.a11; m[1][2] = din.a12;
        m[2][0] = din.a20; m[2][1] = din.a21; m[2][2] = din.a22;
        b[0] = din.b0; b[1] = din.b1; b[2] = din.b2;
    end

    // det uses column 0 of A against the cofactors of column 0, D_k uses b against the cofactors of column k
    always_comb
    begin
        for (int t = 0; t < 4; t++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                coef_op[t][r] = (t == 0) ? m2_reg[r] : b2_reg[r];
                cof_op[t][r]  = cof_reg[r][(t == 0) ? 0 : t - 1];
            end
        end
        for (int t = 0; t < 4; t++)
        begin
            abs_v[t] = sum_reg[t][SW-1] ? -sum_reg[t] : sum_reg[t];
        end
    end

    assign rnd_sum = {1'b0, mag_reg[0]} + RND_HALF;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            // stage 1: pair products of the cyclic cofactor form
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    ppa_reg[r][c] <= m[(r+1)%3][(c+1)%3] * m[(r+2)%3][(c+2)%3];
                    ppb_reg[r][c] <= m[(r+1)%3][(c+2)%3] * m[(r+2)%3][(c+1)%3];
                end
                m1_reg[r] <= m[r][0];
                b1_reg[r] <= b[r];
            end
            // stage 2: cofactors
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    cof_reg[r][c] <= {ppa_reg[r][c][2*W-1], ppa_reg[r][c]}
                                   - {ppb_reg[r][c][2*W-1], ppb_reg[r][c]};
                end
                m2_reg[r] <= m1_reg[r];
                b2_reg[r] <= b1_reg[r];
            end
            // stage 3: split each cofactor into high and low halves and multiply
            for (int t = 0; t < 4; t++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    hi_reg[t][r] <= $signed(cof_op[t][r][CW-1:W]) * coef_op[t][r];
                    lo_reg[t][r] <= $signed({1'b0, cof_op[t][r][W-1:0]}) * coef_op[t][r];
                end
            end
            // stage 4: recombine halves
            for (int t = 0; t < 4; t++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    term_reg[t][r] <= {hi_reg[t][r], {W{1'b0}}}
                                    + {{(SW-PW){lo_reg[t][r][PW-1]}}, lo_reg[t][r]};
                end
            end
            // stage 5: three-term sums
            for (int t = 0; t < 4; t++)
            begin
                sum_reg[t] <= term_reg[t][0] + term_reg[t][1] + term_reg[t][2];
            end
            // stage 6: sign and magnitude
            for (int t = 0; t < 4; t++)
            begin
                neg_reg[t] <= sum_reg[t][SW-1];
                mag_reg[t] <= abs_v[t][MW-1:0];
            end
            // stage 7: threshold test and divider operands
            solved_reg <= (mag_reg[0] != '0)
                       && (rnd_sum[MW:W] >= {{(MW+1-W-THR_W){1'b0}}, thr});
            for (int k = 0; k < 3; k++)
            begin
                div_reg[k].num <= {mag_reg[k+1], {FRAC{1'b0}}};
                div_reg[k].den <= mag_reg[0];
                div_reg[k].neg <= neg_reg[k+1] ^ neg_reg[0];
            end
        end
    end

    assign div_in = div_reg;
    assign solved = solved_reg;

endmodule

// ----- rtl/lss_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with rounding and clipping.
`timescale 1ns / 1ps
module lss_div
(
    input  logic                        clk,
    input  logic                        ce,
    input  lss_pkg::div_in_t            din,
    output logic signed [lss_pkg::W-1:0] x,
    output logic                        sat
);
    import lss_pkg::*;

    logic [RW-1:0] r_reg   [QB+1];
    logic [QB-1:0] q_reg   [QB+1];
    logic [MW-1:0] den_reg [QB+1];
    logic          neg_reg [QB+1];
    logic          ovf_reg [QB+1];
    logic [RW-1:0] dsh     [QB+1];
    logic          ge      [QB+1];
    logic          rup;
    logic [QW-1:0] q_full;
    logic [W-1:0]  x_next;
    logic          sat_next;
    logic [W-1:0]  x_reg;
    logic          sat_reg;

    always_comb
    begin
        dsh[0] = '0;
        ge[0]  = 1'b0;
        for (int s = 1; s <= QB; s++)
        begin
            dsh[s] = RW'(den_reg[s-1]) << (QB - s);
            ge[s]  = r_reg[s-1] >= dsh[s];
        end
    end

    // round half away from zero on the magnitude, then clip to the signed word
    always_comb
    begin
        rup    = {r_reg[QB], 1'b0} >= {{(RW+1-MW){1'b0}}, den_reg[QB]};
        q_full = {1'b0, q_reg[QB]} + QW'(rup);
        if (neg_reg[QB])
        begin
            sat_next = ovf_reg[QB] || (q_full > NEG_LIM);
            x_next   = sat_next ? X_NEG_MIN : -q_full[W-1:0];
        end
        else
        begin
            sat_next = ovf_reg[QB] || (q_full > POS_LIM);
            x_next   = sat_next ? X_POS_MAX : q_full[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            r_reg[0]   <= RW'(din.num);
            q_reg[0]   <= '0;
            den_reg[0] <= din.den;
            neg_reg[0] <= din.neg;
            ovf_reg[0] <= RW'(din.num) >= (RW'(din.den) << QB);
            for (int s = 1; s <= QB; s++)
            begin
                r_reg[s]   <= ge[s] ? r_reg[s-1] - dsh[s] : r_reg[s-1];
                q_reg[s]   <= ge[s] ? (q_reg[s-1] | (QB'(1) << (QB - s))) : q_reg[s-1];
                den_reg[s] <= den_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
            end
            x_reg   <= x_next;
            sat_reg <= sat_next;
        end
    end

    assign x   = x_reg;
    assign sat = sat_reg;

endmodule

// ----- rtl/linear_solve_3x3.sv -----
// Top level of the pipelined 3x3 Cramer's-rule solver in Q16.16.
`timescale 1ns / 1ps
// Usage
//   in_valid/in_ready/in_data carry one system per transfer: nine matrix
//   coefficients and three right-hand values, all signed Q16.16.
//   out_valid/out_ready/out_data carry one result per transfer: solved flag,
//   x0..x2 and a saturated flag. A system whose rounded |det| is below the
//   threshold, or whose det is exactly zero, gives solved = 0 and zeros.
//   cfg_valid/cfg_ready/cfg_data write singular_threshold (always ready);
//   write it only while the pipeline is empty.
// Timing
//   The pipeline is 43 register stages: 7 stages of determinant arithmetic,
//   35 stages per divider (one quotient bit a stage plus entry and rounding)
//   and the output register. Throughput is one system per cycle while no
//   result waits untaken; the 33-stage long division sets the depth.
// Reset and stall
//   Reset empties the pipeline and sets the threshold to 1. When the receiver
//   holds out_ready low with a result waiting, every stage holds together and
//   in_ready drops in the same cycle; nothing is lost or repeated.
module linear_solve_3x3
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lss_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output lss_pkg::out_t                 out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lss_pkg::THR_W-1:0]     cfg_data
);
    import lss_pkg::*;

    localparam int LAT = FRONT_LAT + DIV_LAT + 1;

    logic               ce;
    logic [THR_W-1:0]   thr_reg;
    logic [LAT-1:0]     v_reg;
    logic [DIV_LAT-1:0] sv_reg;
    div_in_t [2:0]      div_in;
    logic               front_solved;
    logic signed [W-1:0] xd [3];
    logic [2:0]         satd;
    logic               sol_last;
    out_t               out_reg;

    // advance the whole pipeline unless a result waits and is not taken
    assign ce        = !v_reg[LAT-1] || out_ready;
    assign in_ready  = ce;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data;
        end
    end

    // valid bits travel alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (ce)
        begin
            v_reg <= {v_reg[LAT-2:0], in_valid};
        end
    end

    lss_front u_front
    (
        .clk    (clk),
        .ce     (ce),
        .din    (in_data),
        .thr    (thr_reg),
        .div_in (div_in),
        .solved (front_solved)
    );

    for (genvar k = 0; k < 3; k++)
    begin : g_div
        lss_div u_div
        (
            .clk (clk),
            .ce  (ce),
            .din (div_in[k]),
            .x   (xd[k]),
            .sat (satd[k])
        );
    end

    // hold the solved flag level with the dividers
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sv_reg <= {sv_reg[DIV_LAT-2:0], front_solved};
        end
    end

    assign sol_last = sv_reg[DIV_LAT-1];

    // output register: drop the quotients of a singular system
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_reg.solved    <= sol_last;
            out_reg.x0        <= sol_last ? xd[0] : '0;
            out_reg.x1        <= sol_last ? xd[1] : '0;
            out_reg.x2        <= sol_last ? xd[2] : '0;
            out_reg.saturated <= sol_last && (|satd);
        end
    end

    assign out_valid = v_reg[LAT-1];
    assign out_data  = out_reg;

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("pipeline advance does not follow the output side");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.solved |->
            out_data.x0 == '0 && out_data.x1 == '0 && out_data.x2 == '0
            && !out_data.saturated)
        else $error("unsolved result carries nonzero data");

    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |->
            out_data.x0 == X_POS_MAX || out_data.x0 == X_NEG_MIN
            || out_data.x1 == X_POS_MAX || out_data.x1 == X_NEG_MIN
            || out_data.x2 == X_POS_MAX || out_data.x2 == X_NEG_MIN)
        else $error("saturated flag set without a clipped element");

    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> thr_reg == $past(cfg_data))
        else $error("threshold write lost");

endmodule
